// File: hw/rtl/mexp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared types, step codes and the control program of the sequencer.
// ----------------------------------------------------------------------------
package mexp_pkg;

   localparam int OPERAND_WIDTH_DEFAULT = 16;
   localparam int STEP_W = 4;

   typedef logic [STEP_W-1:0] step_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_LOAD,
      OP_RED,
      OP_SHIFT,
      OP_DONE,
      OP_ERR
   } op_type;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_NO_START,
      COND_M_ZERO,
      COND_E_ZERO,
      COND_E_BIT_CLEAR,
      COND_E_LAST
   } cond_type;

   typedef enum logic [1:0] {
      MUL_BASE_ONE,
      MUL_ACC_BASE,
      MUL_BASE_BASE
   } mul_sel_type;

   typedef struct packed {
      op_type      op;
      cond_type    cond;
      mul_sel_type mul_sel;
      step_type    target;
   } ctl_word_type;

   typedef struct packed {
      logic m_zero;
      logic e_zero;
      logic e_bit0;
      logic e_last;
      logic red_done;
   } status_type;

   localparam step_type STEP_WAIT      = 4'd0;
   localparam step_type STEP_CHK_M     = 4'd1;
   localparam step_type STEP_CHK_E     = 4'd2;
   localparam step_type STEP_RED_BASE  = 4'd3;
   localparam step_type STEP_TEST_BIT  = 4'd4;
   localparam step_type STEP_MUL_ACC   = 4'd5;
   localparam step_type STEP_SHIFT     = 4'd6;
   localparam step_type STEP_SQUARE    = 4'd7;
   localparam step_type STEP_DONE      = 4'd8;
   localparam step_type STEP_ERR       = 4'd9;

   function automatic ctl_word_type program_rom(input step_type step);
      ctl_word_type w;
      w = '{op: OP_NOP, cond: COND_ALWAYS, mul_sel: MUL_BASE_ONE, target: STEP_WAIT};
      unique case (step)
         STEP_WAIT: begin
            w = '{op: OP_LOAD, cond: COND_NO_START, mul_sel: MUL_BASE_ONE,
                  target: STEP_WAIT};
         end
         STEP_CHK_M: begin
            w = '{op: OP_NOP, cond: COND_M_ZERO, mul_sel: MUL_BASE_ONE,
                  target: STEP_ERR};
         end
         STEP_CHK_E: begin
            w = '{op: OP_NOP, cond: COND_E_ZERO, mul_sel: MUL_BASE_ONE,
                  target: STEP_DONE};
         end
         STEP_RED_BASE: begin
            w = '{op: OP_RED, cond: COND_NEXT, mul_sel: MUL_BASE_ONE,
                  target: STEP_WAIT};
         end
         STEP_TEST_BIT: begin
            w = '{op: OP_NOP, cond: COND_E_BIT_CLEAR, mul_sel: MUL_BASE_ONE,
                  target: STEP_SHIFT};
         end
         STEP_MUL_ACC: begin
            w = '{op: OP_RED, cond: COND_NEXT, mul_sel: MUL_ACC_BASE,
                  target: STEP_WAIT};
         end
         STEP_SHIFT: begin
            w = '{op: OP_SHIFT, cond: COND_E_LAST, mul_sel: MUL_BASE_ONE,
                  target: STEP_DONE};
         end
         STEP_SQUARE: begin
            w = '{op: OP_RED, cond: COND_ALWAYS, mul_sel: MUL_BASE_BASE,
                  target: STEP_TEST_BIT};
         end
         STEP_DONE: begin
            w = '{op: OP_DONE, cond: COND_ALWAYS, mul_sel: MUL_BASE_ONE,
                  target: STEP_WAIT};
         end
         STEP_ERR: begin
            w = '{op: OP_ERR, cond: COND_ALWAYS, mul_sel: MUL_BASE_ONE,
                  target: STEP_WAIT};
         end
         default: begin
            w = '{op: OP_NOP, cond: COND_ALWAYS, mul_sel: MUL_BASE_ONE,
                  target: STEP_WAIT};
         end
      endcase
      return w;
   endfunction

endpackage

// File: hw/rtl/mexp_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation sequencer
// Step counter over the control program, with conditional jumps on datapath
// status and a hold while a reduction is in progress.
// ----------------------------------------------------------------------------
module mexp_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  mexp_pkg::status_type    status,
   output mexp_pkg::ctl_word_type  ctl,
   output logic                    busy
);
   import mexp_pkg::*;

   step_type step_ff;
   step_type step_in;
   logic     take;

   assign ctl  = program_rom(step_ff);
   assign busy = (step_ff != STEP_WAIT);

   always_comb begin
      unique case (ctl.cond)
         COND_NEXT:        take = 1'b0;
         COND_ALWAYS:      take = 1'b1;
         COND_NO_START:    take = !start;
         COND_M_ZERO:      take = status.m_zero;
         COND_E_ZERO:      take = status.e_zero;
         COND_E_BIT_CLEAR: take = !status.e_bit0;
         COND_E_LAST:      take = status.e_last;
         default:          take = 1'b1;
      endcase
   end

   always_comb begin
      if ((ctl.op == OP_RED) && !status.red_done) begin
         step_in = step_ff;
      end else if (take) begin
         step_in = ctl.target;
      end else begin
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// File: hw/rtl/mexp_reducer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation remainder unit
// Bit-serial restoring remainder of a double-width product by the modulus,
// one product bit per cycle.
// ----------------------------------------------------------------------------
module mexp_reducer #(
   parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  logic [2*OPERAND_WIDTH-1:0] product_value,
   input  logic [OPERAND_WIDTH-1:0]   modulus,
   output logic                       done,
   output logic [OPERAND_WIDTH-1:0]   remainder
);
   import mexp_pkg::*;

   localparam int PW    = 2 * OPERAND_WIDTH;
   localparam int CNT_W = $clog2(PW);

   logic                     active_ff, active_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [PW-1:0]            x_ff, x_in;
   logic [OPERAND_WIDTH-1:0] r_ff, r_in;
   logic [OPERAND_WIDTH:0]   shifted;
   logic [OPERAND_WIDTH:0]   diff;

   assign shifted   = {r_ff, x_ff[PW-1]};
   assign diff      = shifted - {1'b0, modulus};
   assign done      = active_ff && (cnt_ff == '0);
   assign remainder = r_in;

   always_comb begin
      if (shifted >= {1'b0, modulus}) begin
         r_in = diff[OPERAND_WIDTH-1:0];
      end else begin
         r_in = shifted[OPERAND_WIDTH-1:0];
      end
   end

   always_comb begin
      active_in = active_ff;
      cnt_in    = cnt_ff;
      x_in      = x_ff;
      if (load && !active_ff) begin
         active_in = 1'b1;
         cnt_in    = CNT_W'(PW - 1);
         x_in      = product_value;
      end else if (active_ff) begin
         x_in   = {x_ff[PW-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      if (load && !active_ff) begin
         r_ff <= '0;
      end else if (active_ff) begin
         r_ff <= r_in;
      end
   end

endmodule

// File: hw/rtl/mexp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation datapath
// Operand, accumulator and exponent registers, the multiplier and the result
// registers, driven by the current control word.
// ----------------------------------------------------------------------------
module mexp_datapath #(
   parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  mexp_pkg::ctl_word_type        ctl,
   input  logic [OPERAND_WIDTH-1:0]      req_base_value,
   input  logic [OPERAND_WIDTH-1:0]      req_exponent,
   input  logic [OPERAND_WIDTH-1:0]      req_modulus,
   output mexp_pkg::status_type          status,
   output logic                          rsp_valid,
   output logic [OPERAND_WIDTH-1:0]      rsp_power_result,
   output logic                          rsp_zero_modulus_error
);
   import mexp_pkg::*;

   localparam int W = OPERAND_WIDTH;

   logic [W-1:0]   base_ff, acc_ff, exp_ff, mod_ff;
   logic [W-1:0]   mul_a, mul_b;
   logic [2*W-1:0] product;
   logic           red_done;
   logic [W-1:0]   red_rem;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]   result_ff;
   logic           error_ff;

   always_comb begin
      unique case (ctl.mul_sel)
         MUL_BASE_ONE: begin
            mul_a = base_ff;
            mul_b = W'(1);
         end
         MUL_ACC_BASE: begin
            mul_a = acc_ff;
            mul_b = base_ff;
         end
         MUL_BASE_BASE: begin
            mul_a = base_ff;
            mul_b = base_ff;
         end
         default: begin
            mul_a = base_ff;
            mul_b = W'(1);
         end
      endcase
   end

   assign product = mul_a * mul_b;

   mexp_reducer #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_reducer (
      .clock         (clock),
      .reset         (reset),
      .load          (ctl.op == OP_RED),
      .product_value (product),
      .modulus       (mod_ff),
      .done          (red_done),
      .remainder     (red_rem)
   );

   assign status.m_zero   = (mod_ff == '0);
   assign status.e_zero   = (exp_ff == '0);
   assign status.e_bit0   = exp_ff[0];
   assign status.e_last   = (exp_ff[W-1:1] == '0);
   assign status.red_done = red_done;

   always_ff @(posedge clock) begin
      if ((ctl.op == OP_LOAD) && start) begin
         base_ff <= req_base_value;
         exp_ff  <= req_exponent;
         mod_ff  <= req_modulus;
         acc_ff  <= W'(1);
      end else if ((ctl.op == OP_RED) && red_done) begin
         if (ctl.mul_sel == MUL_ACC_BASE) begin
            acc_ff <= red_rem;
         end else begin
            base_ff <= red_rem;
         end
      end else if (ctl.op == OP_SHIFT) begin
         exp_ff <= exp_ff >> 1;
      end
   end

   assign rsp_valid_in = (ctl.op == OP_DONE) || (ctl.op == OP_ERR);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.op == OP_DONE) begin
         result_ff <= acc_ff;
         error_ff  <= 1'b0;
      end else if (ctl.op == OP_ERR) begin
         result_ff <= '0;
         error_ff  <= 1'b1;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_power_result       = result_ff;
   assign rsp_zero_modulus_error = error_ff;

endmodule

// File: hw/rtl/modular_exponentiation_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation unit
// Computes base^exponent mod modulus by right-to-left square-and-multiply,
// run by a microcoded sequencer over a multiplier and a serial remainder unit.
//
//   Channel   Ports                                          Handshake
//   request   req_base_value, req_exponent, req_modulus      start & !busy
//   response  rsp_power_result, rsp_zero_modulus_error       rsp_valid strobe
//
// One item is in flight at a time; busy stays high from acceptance until the
// result strobe. Each modular reduction runs bit-serially in the remainder
// unit, and each exponent bit needs up to two of them plus two control steps.
// A zero modulus or zero exponent is answered without any reduction.
// Reset is synchronous and returns the sequencer to its wait step. The
// receiver cannot stall: the result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit #(
   parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [OPERAND_WIDTH-1:0] req_base_value,
   input  logic [OPERAND_WIDTH-1:0] req_exponent,
   input  logic [OPERAND_WIDTH-1:0] req_modulus,
   output logic                     rsp_valid,
   output logic [OPERAND_WIDTH-1:0] rsp_power_result,
   output logic                     rsp_zero_modulus_error
);
   import mexp_pkg::*;

   ctl_word_type ctl;
   status_type   status;

   mexp_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .ctl    (ctl),
      .busy   (busy)
   );

   mexp_datapath #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .ctl                    (ctl),
      .req_base_value         (req_base_value),
      .req_exponent           (req_exponent),
      .req_modulus            (req_modulus),
      .status                 (status),
      .rsp_valid              (rsp_valid),
      .rsp_power_result       (rsp_power_result),
      .rsp_zero_modulus_error (rsp_zero_modulus_error)
   );

endmodule
